FILE: design/rbht_pkg.sv
// Shared widths, status codes and transfer types for the RNG buffer health test.
package rbht_pkg;

    localparam int MAX_BYTES = 4096;

    localparam int LEN_W  = $clog2(MAX_BYTES + 1);
    localparam int ONES_W = $clog2(8 * MAX_BYTES + 1);
    localparam int TR_W   = $clog2(8 * MAX_BYTES);
    localparam int CMP_W  = LEN_W + 3;

    localparam int STATUS_W     = 3;
    localparam int OUT_ONES_W   = 16;
    localparam int OUT_TR_W     = 15;
    localparam int OUT_LEN_W    = 13;
    localparam int OUT_FIELDS_W = STATUS_W + OUT_ONES_W + OUT_TR_W + OUT_LEN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int MIN_LEN = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_PASS     = 3'd0,
        ST_STUCK    = 3'd1,
        ST_BIAS     = 3'd2,
        ST_TRANS    = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    // per-byte figures from the bit counter
    typedef struct packed {
        logic [3:0] ones;
        logic [3:0] trans;
        logic       is_zero;
        logic       is_full;
        logic       last_bit;
    } t_byte_stats;

    typedef struct packed {
        t_status           status;
        logic [ONES_W-1:0] ones;
        logic [TR_W-1:0]   trans;
        logic [LEN_W-1:0]  len;
    } t_result;

endpackage

FILE: design/rng_buffer_health_test.sv
// A byte transfer reaches its result on o_m_axis through the input register and then the result register.
// Throughput: one byte per cycle; the input register drains as soon as the result register
// can take the buffer verdict, so only a stalled result slot holds a last byte back.
// Counts are kept in running accumulators updated as each byte leaves the input register.
// Reset (i_rst_n low, synchronous) clears all counters and both valid flags.
// A new buffer starts with the byte after each last byte.
module rng_buffer_health_test
    import rbht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tlast,   // last_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] status, [18:3] ones_total, [33:19] transition_total, [46:34] buffer_length
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    logic    r_out_valid;
    t_result r_out;

    logic    w_out_free;
    logic    w_adv;
    t_result w_result;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    rbht_counters u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_data   (r_in_data),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out <= w_result;
        end
    end

    logic [31:0] w_ones_x, w_trans_x, w_len_x;
    assign w_ones_x  = 32'(r_out.ones);
    assign w_trans_x = 32'(r_out.trans);
    assign w_len_x   = 32'(r_out.len);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                              w_len_x[OUT_LEN_W-1:0],
                              w_trans_x[OUT_TR_W-1:0],
                              w_ones_x[OUT_ONES_W-1:0],
                              r_out.status};

    // a held byte in the input register only accepts a new transfer when it moves on
    a_in_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_s_axis_tready) |-> w_adv)
        else $error("input register overwritten while occupied");

    // every last byte that leaves the input register yields a result
    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> o_m_axis_tvalid)
        else $error("last byte dropped without result");

    // an overflowed buffer reports exactly MAX_BYTES counted bytes
    a_too_long_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_TOO_LONG) |-> (r_out.len == LEN_W'(MAX_BYTES)))
        else $error("too-long verdict with wrong length");

    // a passing buffer of at least MIN_LEN bytes has a consistent set-bit count
    a_pass_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_PASS && r_out.len >= LEN_W'(MIN_LEN))
        |-> (w_ones_x >= 3 * w_len_x && w_ones_x <= 5 * w_len_x))
        else $error("pass verdict with biased bit count");

endmodule

FILE: design/rbht_byte_stats.sv
// Per-byte popcount, transition count and stuck-byte flags.
module rbht_byte_stats
    import rbht_pkg::*;
(
    input  logic [7:0]  i_data,
    input  logic        i_prev_bit,
    output t_byte_stats o_stats
);

    logic [3:0] w_ones;
    logic [3:0] w_trans;

    always_comb begin
        w_ones  = 4'd0;
        w_trans = {3'd0, i_data[0] ^ i_prev_bit};
        for (int j = 0; j < 8; j++) begin
            w_ones = w_ones + {3'd0, i_data[j]};
        end
        for (int j = 1; j < 8; j++) begin
            w_trans = w_trans + {3'd0, i_data[j] ^ i_data[j-1]};
        end
    end

    assign o_stats.ones     = w_ones;
    assign o_stats.trans    = w_trans;
    assign o_stats.is_zero  = (i_data == 8'h00);
    assign o_stats.is_full  = (i_data == 8'hFF);
    assign o_stats.last_bit = i_data[7];

endmodule

FILE: design/rbht_counters.sv
// Buffer counters, length limit and end-of-buffer verdict.
module rbht_counters
    import rbht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output t_result    o_result
);

    logic [LEN_W-1:0]  r_len,   n_len;
    logic [LEN_W-1:0]  r_zeros, n_zeros;
    logic [LEN_W-1:0]  r_fulls, n_fulls;
    logic [ONES_W-1:0] r_ones,  n_ones;
    logic [TR_W-1:0]   r_trans, n_trans;
    logic              r_prev,  n_prev;
    logic              r_ovf,   n_ovf;

    logic        w_prev_in;
    t_byte_stats w_stats;

    // first byte of a buffer has no earlier bit
    assign w_prev_in = (r_len == '0) ? i_data[0] : r_prev;

    rbht_byte_stats u_stats (
        .i_data     (i_data),
        .i_prev_bit (w_prev_in),
        .o_stats    (w_stats)
    );

    always_comb begin
        n_len   = r_len;
        n_zeros = r_zeros;
        n_fulls = r_fulls;
        n_ones  = r_ones;
        n_trans = r_trans;
        n_prev  = r_prev;
        n_ovf   = r_ovf;
        if (!r_ovf) begin
            if (r_len == LEN_W'(MAX_BYTES)) begin
                n_ovf = 1'b1;
            end else begin
                n_len   = r_len + LEN_W'(1);
                n_zeros = r_zeros + LEN_W'(w_stats.is_zero);
                n_fulls = r_fulls + LEN_W'(w_stats.is_full);
                n_ones  = r_ones + ONES_W'(w_stats.ones);
                n_trans = r_trans + TR_W'(w_stats.trans);
                n_prev  = w_stats.last_bit;
            end
        end
    end

    logic [LEN_W-1:0] w_half;
    logic [CMP_W-1:0] w_len_x, w_three, w_five, w_ones_x, w_trans_x;
    t_status          w_status;

    assign w_half    = n_len >> 1;
    assign w_len_x   = CMP_W'(n_len);
    assign w_three   = (w_len_x << 1) + w_len_x;
    assign w_five    = (w_len_x << 2) + w_len_x;
    assign w_ones_x  = CMP_W'(n_ones);
    assign w_trans_x = CMP_W'(n_trans);

    always_comb begin
        if (n_ovf) begin
            w_status = ST_TOO_LONG;
        end else if (n_len < LEN_W'(MIN_LEN)) begin
            w_status = ST_PASS;
        end else if (n_zeros > w_half || n_fulls > w_half) begin
            w_status = ST_STUCK;
        end else if (w_ones_x < w_three || w_ones_x > w_five) begin
            w_status = ST_BIAS;
        end else if (w_trans_x < w_three || w_trans_x > w_five - CMP_W'(2)) begin
            w_status = ST_TRANS;
        end else begin
            w_status = ST_PASS;
        end
    end

    assign o_result.status = w_status;
    assign o_result.ones   = n_ones;
    assign o_result.trans  = n_trans;
    assign o_result.len    = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_len   <= '0;
            r_zeros <= '0;
            r_fulls <= '0;
            r_ones  <= '0;
            r_trans <= '0;
            r_prev  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_en) begin
            r_len   <= n_len;
            r_zeros <= n_zeros;
            r_fulls <= n_fulls;
            r_ones  <= n_ones;
            r_trans <= n_trans;
            r_prev  <= n_prev;
            r_ovf   <= n_ovf;
        end
    end

endmodule

FILE: bench/tb.sv
// Stream testbench for the RNG buffer health test: driver, monitor and verdict predictor.
`timescale 1ns / 100ps

module tb;
    import rbht_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct {
        t_status                status;
        logic [OUT_ONES_W-1:0] ones;
        logic [OUT_TR_W-1:0]   trans;
        logic [OUT_LEN_W-1:0]  len;
    } t_verdict;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  s_tlast  = 1'b0;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [OUT_DATA_W-1:0] m_tdata;

    t_byte_item pending_q[$];
    t_verdict   verdict_q[$];

    logic in_fire     = 1'b0;
    logic calm        = 1'b0;
    int   hold_ticket = 0;
    int   err_cnt     = 0;

    // running counts of the buffer being received
    logic [LEN_W-1:0]  buf_len   = '0;
    logic [LEN_W-1:0]  buf_zeros = '0;
    logic [LEN_W-1:0]  buf_fulls = '0;
    logic [ONES_W-1:0] buf_ones  = '0;
    logic [TR_W-1:0]   buf_trans = '0;
    logic              buf_prev  = 1'b0;
    logic              buf_over  = 1'b0;

    rng_buffer_health_test dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // Fold one accepted byte into the running counts; on a last byte queue the verdict.
    task automatic tally_byte(input logic [7:0] b, input logic last);
        int       j, n, half, ones, trans;
        logic     prev;
        t_verdict v;
        if (!buf_over) begin
            if (buf_len >= MAX_BYTES) begin
                buf_over = 1'b1;
            end else begin
                // first byte of a buffer: bit 0 has no predecessor
                prev = (buf_len == 0) ? b[0] : buf_prev;
                if (b == 8'h00) buf_zeros++;
                if (b == 8'hFF) buf_fulls++;
                for (j = 0; j < 8; j++) begin
                    buf_ones  += ONES_W'(b[j]);
                    buf_trans += TR_W'(b[j] ^ prev);
                    prev = b[j];
                end
                buf_prev = prev;
                buf_len++;
            end
        end
        if (last) begin
            n     = int'(buf_len);
            half  = n / 2;
            ones  = int'(buf_ones);
            trans = int'(buf_trans);
            if (buf_over)
                v.status = ST_TOO_LONG;
            else if (n < MIN_LEN)
                v.status = ST_PASS;
            else if (buf_zeros > half || buf_fulls > half)
                v.status = ST_STUCK;
            else if (ones < 3 * n || ones > 5 * n)
                v.status = ST_BIAS;
            else if (trans < 3 * n || trans > 5 * n - 2)
                v.status = ST_TRANS;
            else
                v.status = ST_PASS;
            v.ones  = OUT_ONES_W'(buf_ones);
            v.trans = OUT_TR_W'(buf_trans);
            v.len   = OUT_LEN_W'(buf_len);
            verdict_q.push_back(v);
            buf_len   = '0;
            buf_zeros = '0;
            buf_fulls = '0;
            buf_ones  = '0;
            buf_trans = '0;
            buf_prev  = 1'b0;
            buf_over  = 1'b0;
        end
    endtask

    // Monitor: check result transfers, then feed accepted bytes to the predictor.
    always @(posedge clk) begin
        t_verdict got, want;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got.status = t_status'(m_tdata[STATUS_W-1:0]);
                got.ones   = m_tdata[STATUS_W +: OUT_ONES_W];
                got.trans  = m_tdata[STATUS_W + OUT_ONES_W +: OUT_TR_W];
                got.len    = m_tdata[STATUS_W + OUT_ONES_W + OUT_TR_W +: OUT_LEN_W];
                if (verdict_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected result: status %0d ones %0d trans %0d len %0d",
                                 got.status, got.ones, got.trans, got.len);
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.status != want.status || got.ones != want.ones ||
                        got.trans != want.trans || got.len != want.len) begin
                        if (err_cnt < 10)
                            $display({"mismatch: exp status %0d ones %0d trans %0d len %0d, ",
                                      "got status %0d ones %0d trans %0d len %0d"},
                                     want.status, want.ones, want.trans, want.len,
                                     got.status, got.ones, got.trans, got.len);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                tally_byte(s_tdata, s_tlast);
        end
    end

    // Driver: holds an offered byte until its transfer, idles in random bursts.
    int tx_gap   = 0;
    int tx_quiet = 0;
    always @(negedge clk) begin
        logic go;
        if (in_fire)
            void'(pending_q.pop_front());
        if (s_tvalid && !in_fire) begin
            go = 1'b1;
        end else if (pending_q.size() == 0) begin
            go = 1'b0;
        end else if (tx_gap > 0 && !calm) begin
            tx_gap--;
            go = 1'b0;
        end else if (!calm && tx_quiet == 0 && $urandom_range(0, 7) == 0) begin
            tx_gap = $urandom_range(1, 14) - 1;
            go = 1'b0;
        end else begin
            go = 1'b1;
            if (tx_quiet > 0)
                tx_quiet--;
            else if (!calm && $urandom_range(0, 99) == 0)
                tx_quiet = $urandom_range(30, 150);
        end
        s_tvalid <= go;
        if (go) begin
            s_tdata <= pending_q[0].data;
            s_tlast <= pending_q[0].last;
        end
    end

    // Receiver: random back-pressure plus a long hold-off on request.
    int rx_gap    = 0;
    int rx_quiet  = 0;
    int rx_hold   = 0;
    int rx_served = 0;
    always @(negedge clk) begin
        logic rdy;
        if (rx_served != hold_ticket) begin
            rx_served = hold_ticket;
            rx_hold   = 300;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            rdy = 1'b0;
        end else if (rx_gap > 0 && !calm) begin
            rx_gap--;
            rdy = 1'b0;
        end else if (!calm && rx_quiet == 0 && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 14) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (rx_quiet > 0)
                rx_quiet--;
            else if (!calm && $urandom_range(0, 99) == 0)
                rx_quiet = $urandom_range(30, 150);
        end
        m_tready <= rdy;
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_byte_item it;
        it.data = b;
        it.last = last;
        pending_q.push_back(it);
    endtask

    task automatic push_fill(input int n, input logic [7:0] b);
        int j;
        for (j = 0; j < n; j++)
            push_byte(b, j == n - 1);
    endtask

    // One buffer of n bytes with a randomly chosen statistical flavor.
    task automatic push_random_buffer(input int n);
        int         style, pct, j, k;
        logic [7:0] b;
        logic [7:0] stuck_val;
        logic       bitv;
        logic [7:0] pool[10] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F,
                                 8'hF0, 8'h01, 8'hFE, 8'h07, 8'h1F};
        style     = $urandom_range(0, 9);
        pct       = $urandom_range(20, 80);
        stuck_val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        bitv      = 1'($urandom_range(0, 1));
        for (j = 0; j < n; j++) begin
            case (style) inside
                4, 5: begin
                    // independent bits, biased set probability
                    for (k = 0; k < 8; k++)
                        b[k] = ($urandom_range(0, 99) < pct);
                end
                6, 7: begin
                    // bit stream with a chosen flip rate
                    for (k = 0; k < 8; k++) begin
                        if ($urandom_range(0, 99) < pct)
                            bitv = ~bitv;
                        b[k] = bitv;
                    end
                end
                8: b = ($urandom_range(0, 99) < 55) ? stuck_val : 8'($urandom);
                9: b = pool[$urandom_range(0, 9)];
                default: b = 8'($urandom);
            endcase
            push_byte(b, j == n - 1);
        end
    endtask

    task automatic wait_drain();
        do begin
            @(posedge clk);
            #1;
        end while (pending_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
    endtask

    initial begin
        int sent, n, r, j, zeros;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // directed: single-byte extremes, stuck buffer, high transitions, short buffer
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_fill(8, 8'h00);
        push_fill(8, 8'h55);
        push_fill(7, 8'h01);
        wait_drain();

        // fixed patterns at random lengths: bias both ways, low transitions, edges
        push_fill($urandom_range(8, 24), 8'h01);
        push_fill($urandom_range(8, 24), 8'hFE);
        push_fill($urandom_range(8, 24), 8'h0F);
        push_fill($urandom_range(8, 24), 8'hAA);
        push_fill($urandom_range(8, 24), 8'h07);
        push_fill($urandom_range(8, 24), 8'h1F);
        push_fill($urandom_range(8, 24), 8'hFF);
        // zero or full bytes at exactly half, and one over half
        for (r = 0; r < 4; r++) begin
            n     = 2 * $urandom_range(4, 12);
            zeros = n / 2 + (r % 2);
            for (j = 0; j < n; j++) begin
                if (j < zeros)
                    push_byte((r < 2) ? 8'h00 : 8'hFF, j == n - 1);
                else
                    push_byte(8'($urandom), j == n - 1);
            end
        end
        wait_drain();

        sent = 0;
        while (sent < 1300) begin
            if (sent > 700 && hold_ticket == 0) begin
                // long receiver stall while short buffers keep coming
                hold_ticket = 1;
                for (j = 0; j < 25; j++) begin
                    n = $urandom_range(1, 3);
                    push_random_buffer(n);
                    sent += n;
                end
            end
            r = $urandom_range(0, 19);
            if (r < 3)
                n = $urandom_range(1, 7);
            else if (r == 3)
                n = 8;
            else if (r == 4)
                n = 9;
            else if (r == 5)
                n = $urandom_range(100, 300);
            else
                n = $urandom_range(8, 40);
            push_random_buffer(n);
            sent += n;
        end
        wait_drain();

        calm = 1'b1;
        for (j = 0; j < 10; j++)
            push_random_buffer($urandom_range(8, 20));
        wait_drain();
        repeat (10) @(posedge clk);

        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("** rng_buffer_health_test: PASSED **");
        end else begin
            $display("** rng_buffer_health_test: FAILED **");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("** rng_buffer_health_test: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/rbht_pkg.sv
design/rbht_byte_stats.sv
design/rbht_counters.sv
design/rng_buffer_health_test.sv
bench/tb.sv
